// ----- rtl/acpi_pm_pkg.sv -----
`default_nettype none

package acpi_pm_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE      = 2'd0,
      ACT_READ       = 2'd1,
      ACT_EVENT      = 2'd2,
      ACT_SOFT_RESET = 2'd3
   } action_type;

   localparam logic [2:0] REG_PM1A_CONTROL = 3'd0;
   localparam logic [2:0] REG_PM1B_CONTROL = 3'd1;
   localparam logic [2:0] REG_SMI_COMMAND  = 3'd2;
   localparam logic [2:0] REG_GPE_ENABLE   = 3'd3;
   localparam logic [2:0] REG_GPE_STATUS   = 3'd4;

   localparam int unsigned SCI_EN_BIT  = 0;
   localparam int unsigned SLP_EN_BIT  = 13;
   localparam int unsigned SLP_TYP_LSB = 10;

   localparam logic [7:0]  SMI_ENABLE       = 8'hF0;
   localparam logic [7:0]  SMI_DISABLE      = 8'hF1;
   localparam logic [31:0] GPE_ENABLE_RESET = 32'hFFFF_FFFF;
   localparam logic [2:0]  SLP_TYP_S5_ALIAS = 3'd7;
   localparam logic [2:0]  SLEEP_S5         = 3'd5;
   localparam logic [2:0]  SLEEP_S0         = 3'd0;

   typedef struct packed {
      action_type  action;
      logic [2:0]  reg_select;
      logic [31:0] write_value;
      logic [4:0]  event_bit;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  power_state;
      logic        sci_fired;
      logic        access_status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/acpi_power_event_registers.sv -----
// Path: an accepted word goes to the input stage, then to the result stage that drives rsp_.
// Throughput: one word per cycle while rsp_stall is low; input and result registers are each
//   a single short pass, and the register state updates as the word leaves the input stage.
// Reset: synchronous, active high; clears both stage valids and restores PM1a/PM1b,
//   SMI command and GPE status to zero, GPE enable to all ones and the sleep state to S0.
`default_nettype none

module acpi_power_event_registers (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [2:0]  req_reg_select,
   input  wire  [31:0] req_write_value,
   input  wire  [4:0]  req_event_bit,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_power_state,
   output logic        rsp_sci_fired,
   output logic        rsp_access_status
);
   import acpi_pm_pkg::*;

   // input stage: holds one word ahead of the register logic
   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;
   // result stage: holds a finished word until the sink takes it
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic out_ready;
   logic fire;
   logic req_accept;
   rsp_type core_result;

   // advance the result stage whenever it is empty or being drained
   assign out_ready  = !out_valid_ff || !rsp_stall;
   // fire: the word in the input stage executes and its result is captured
   assign fire       = in_valid_ff && out_ready;
   // stall the source only while the input stage is full and cannot move on
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_in              = in_ff;
      in_valid_in        = in_valid_ff;
      if (req_accept) begin
         in_valid_in        = 1'b1;
         in_in.action       = action_type'(req_action);
         in_in.reg_select   = req_reg_select;
         in_in.write_value  = req_write_value;
         in_in.event_bit    = req_event_bit;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   acpi_pm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cmd    (in_ff),
      .result (core_result)
   );

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_in       = core_result;
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         // drop the word the sink just took
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_ff.read_data;
   assign rsp_power_state   = out_ff.power_state;
   assign rsp_sci_fired     = out_ff.sci_fired;
   assign rsp_access_status = out_ff.access_status;

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("executed word not captured in result stage");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !fire)
      else $error("result stage overwritten while stalled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("source stalled with room in the pipeline");

endmodule

`default_nettype wire

// ----- rtl/acpi_pm_core.sv -----
`default_nettype none

module acpi_pm_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  fire,
   input  acpi_pm_pkg::req_type cmd,
   output acpi_pm_pkg::rsp_type result
);
   import acpi_pm_pkg::*;

   logic [15:0] pm1a_ff, pm1a_in;
   logic [15:0] pm1b_ff, pm1b_in;
   logic [7:0]  smi_ff, smi_in;
   logic [31:0] status_ff, status_in;
   logic [31:0] enable_ff, enable_in;
   logic [2:0]  sleep_ff, sleep_in;
   logic [31:0] event_mask;
   logic [2:0]  slp_typ;

   assign event_mask = 32'd1 << cmd.event_bit;
   assign slp_typ    = cmd.write_value[SLP_TYP_LSB +: 3];

   always_comb begin
      pm1a_in   = pm1a_ff;
      pm1b_in   = pm1b_ff;
      smi_in    = smi_ff;
      status_in = status_ff;
      enable_in = enable_ff;
      sleep_in  = sleep_ff;
      result    = '0;
      case (cmd.action)
         ACT_WRITE: begin
            case (cmd.reg_select)
               REG_PM1A_CONTROL: begin
                  pm1a_in = cmd.write_value[15:0];
                  if (cmd.write_value[SLP_EN_BIT]) begin
                     sleep_in = (slp_typ == SLP_TYP_S5_ALIAS) ? SLEEP_S5 : slp_typ;
                  end
               end
               REG_PM1B_CONTROL: pm1b_in = cmd.write_value[15:0];
               REG_SMI_COMMAND: begin
                  smi_in = cmd.write_value[7:0];
                  if (cmd.write_value[7:0] == SMI_ENABLE) begin
                     pm1a_in[SCI_EN_BIT] = 1'b1;
                  end else if (cmd.write_value[7:0] == SMI_DISABLE) begin
                     pm1a_in[SCI_EN_BIT] = 1'b0;
                  end
               end
               REG_GPE_ENABLE: enable_in = cmd.write_value;
               REG_GPE_STATUS: status_in = cmd.write_value;
               default: result.access_status = 1'b1;
            endcase
         end
         ACT_READ: begin
            case (cmd.reg_select)
               REG_PM1A_CONTROL: result.read_data = {16'd0, pm1a_ff};
               REG_PM1B_CONTROL: result.read_data = {16'd0, pm1b_ff};
               REG_SMI_COMMAND:  result.read_data = {24'd0, smi_ff};
               REG_GPE_ENABLE:   result.read_data = enable_ff;
               REG_GPE_STATUS:   result.read_data = status_ff;
               default:          result.access_status = 1'b1;
            endcase
         end
         ACT_EVENT: begin
            // an enabled event with SCI_EN set goes to SCI and drops its status bit; else the bit is set
            if (((enable_ff & event_mask) != '0) && pm1a_ff[SCI_EN_BIT]) begin
               status_in        = status_ff & ~event_mask;
               result.sci_fired = 1'b1;
            end else begin
               status_in = status_ff | event_mask;
            end
         end
         default: begin
            pm1a_in   = '0;
            pm1b_in   = '0;
            smi_in    = '0;
            status_in = '0;
            enable_in = GPE_ENABLE_RESET;
            sleep_in  = SLEEP_S0;
         end
      endcase
      result.power_state = sleep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm1a_ff   <= '0;
         pm1b_ff   <= '0;
         smi_ff    <= '0;
         status_ff <= '0;
         enable_ff <= GPE_ENABLE_RESET;
         sleep_ff  <= SLEEP_S0;
      end else if (fire) begin
         pm1a_ff   <= pm1a_in;
         pm1b_ff   <= pm1b_in;
         smi_ff    <= smi_in;
         status_ff <= status_in;
         enable_ff <= enable_in;
         sleep_ff  <= sleep_in;
      end
   end

   a_soft_reset: assert property (@(posedge clock) disable iff (reset)
      fire && cmd.action == ACT_SOFT_RESET |=>
         sleep_ff == SLEEP_S0 && enable_ff == GPE_ENABLE_RESET && status_ff == '0)
      else $error("soft reset did not restore state");

   a_sci_needs_enable: assert property (@(posedge clock) disable iff (reset)
      result.sci_fired |-> cmd.action == ACT_EVENT && pm1a_ff[SCI_EN_BIT])
      else $error("SCI raised without SCI_EN or outside an event");

   a_sci_clears_status: assert property (@(posedge clock) disable iff (reset)
      fire && result.sci_fired |=> !status_ff[$past(cmd.event_bit)])
      else $error("status bit left set after SCI");

   a_unknown_reg: assert property (@(posedge clock) disable iff (reset)
      result.access_status |->
         cmd.reg_select == 3'd5 || cmd.reg_select == 3'd6 || cmd.reg_select == 3'd7)
      else $error("access error on a known register");

endmodule

`default_nettype wire
